FILE: src/lcdmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdmt_pkg
// shared types and constants for the lcd mode and line timing block
// ----------------------------------------------------------------------------
package lcdmt_pkg;

  localparam int unsigned CfgCount     = 6;
  localparam int unsigned CfgAddrWidth = 5;
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic [CfgIdxWidth-1:0] REG_OAM_CYCLES      = 3'd0;
  localparam logic [CfgIdxWidth-1:0] REG_TRANSFER_CYCLES = 3'd1;
  localparam logic [CfgIdxWidth-1:0] REG_HBLANK_CYCLES   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] REG_VBLANK_CYCLES   = 3'd3;
  localparam logic [CfgIdxWidth-1:0] REG_VISIBLE_LINES   = 3'd4;
  localparam logic [CfgIdxWidth-1:0] REG_TOTAL_LINES     = 3'd5;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam logic [9:0] RST_OAM_CYCLES      = 10'd80;
  localparam logic [9:0] RST_TRANSFER_CYCLES = 10'd172;
  localparam logic [9:0] RST_HBLANK_CYCLES   = 10'd204;
  localparam logic [9:0] RST_VBLANK_CYCLES   = 10'd576;
  localparam logic [7:0] RST_VISIBLE_LINES   = 8'd144;
  localparam logic [7:0] RST_TOTAL_LINES     = 8'd154;

  typedef struct packed {
    logic [9:0] oam_cycles;
    logic [9:0] transfer_cycles;
    logic [9:0] hblank_cycles;
    logic [9:0] vblank_line_cycles;
    logic [7:0] visible_lines;
    logic [7:0] total_lines;
  } cfg_t;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_on;
    logic [7:0] compare_line;
    logic       hblank_int_en;
    logic       vblank_int_en;
    logic       oam_int_en;
    logic       match_int_en;
  } in_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_line;
    logic       hblank_start;
  } out_item_t;

endpackage

FILE: src/lcdmt_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdmt_regs
// apb configuration registers for the timing thresholds and line counts
// ----------------------------------------------------------------------------
module lcdmt_regs
  import lcdmt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t                   cfg_q;
  logic                   wr_en;
  logic [CfgIdxWidth-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[CfgAddrWidth-1:2];
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oam_cycles         <= RST_OAM_CYCLES;
      cfg_q.transfer_cycles    <= RST_TRANSFER_CYCLES;
      cfg_q.hblank_cycles      <= RST_HBLANK_CYCLES;
      cfg_q.vblank_line_cycles <= RST_VBLANK_CYCLES;
      cfg_q.visible_lines      <= RST_VISIBLE_LINES;
      cfg_q.total_lines        <= RST_TOTAL_LINES;
    end else if (wr_en) begin
      case (idx)
        REG_OAM_CYCLES:      cfg_q.oam_cycles         <= pwdata[9:0];
        REG_TRANSFER_CYCLES: cfg_q.transfer_cycles    <= pwdata[9:0];
        REG_HBLANK_CYCLES:   cfg_q.hblank_cycles      <= pwdata[9:0];
        REG_VBLANK_CYCLES:   cfg_q.vblank_line_cycles <= pwdata[9:0];
        REG_VISIBLE_LINES:   cfg_q.visible_lines      <= pwdata[7:0];
        REG_TOTAL_LINES:     cfg_q.total_lines        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OAM_CYCLES:      prdata = {22'd0, cfg_q.oam_cycles};
      REG_TRANSFER_CYCLES: prdata = {22'd0, cfg_q.transfer_cycles};
      REG_HBLANK_CYCLES:   prdata = {22'd0, cfg_q.hblank_cycles};
      REG_VBLANK_CYCLES:   prdata = {22'd0, cfg_q.vblank_line_cycles};
      REG_VISIBLE_LINES:   prdata = {24'd0, cfg_q.visible_lines};
      REG_TOTAL_LINES:     prdata = {24'd0, cfg_q.total_lines};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/lcdmt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdmt_core
// mode, line, dot counter and match state with the single-step update logic
// ----------------------------------------------------------------------------
module lcdmt_core
  import lcdmt_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t result_o
);

  logic [1:0]              mode_q, mode_d;
  logic [7:0]              line_q, line_d;
  logic [COUNTER_BITS-1:0] dot_q, dot_d;
  logic                    match_q, match_d;

  logic [COUNTER_BITS:0]   dot_sum;
  logic [COUNTER_BITS-1:0] dot_sat;
  logic [COUNTER_BITS-1:0] need;
  logic                    take;
  logic [7:0]              line_inc;
  logic                    vb, st, draw, hbs;

  assign dot_sum  = {1'b0, dot_q} + (COUNTER_BITS+1)'(item_i.cycles);
  assign dot_sat  = dot_sum[COUNTER_BITS] ? '1 : dot_sum[COUNTER_BITS-1:0];
  assign line_inc = line_q + 8'd1;

  always_comb begin
    case (mode_q)
      MODE_HBLANK: need = COUNTER_BITS'(cfg_i.hblank_cycles);
      MODE_VBLANK: need = COUNTER_BITS'(cfg_i.vblank_line_cycles);
      MODE_OAM:    need = COUNTER_BITS'(cfg_i.oam_cycles);
      default:     need = COUNTER_BITS'(cfg_i.transfer_cycles);
    endcase
  end

  assign take = (dot_sat >= need);

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    dot_d   = dot_sat;
    match_d = match_q;
    vb      = 1'b0;
    st      = 1'b0;
    draw    = 1'b0;
    hbs     = 1'b0;
    if (!item_i.lcd_on) begin
      mode_d = MODE_HBLANK;
      line_d = 8'd0;
      dot_d  = '0;
    end else begin
      if (take) begin
        dot_d = dot_sat - need;
        case (mode_q)
          MODE_HBLANK: begin
            line_d = line_inc;
            if (line_inc == cfg_i.visible_lines) begin
              mode_d = MODE_VBLANK;
              vb     = 1'b1;
              st     = item_i.vblank_int_en;
            end else begin
              mode_d = MODE_OAM;
              st     = item_i.oam_int_en;
            end
          end
          MODE_VBLANK: begin
            line_d = line_inc;
            if (line_inc == cfg_i.total_lines) begin
              line_d = 8'd0;
              mode_d = MODE_OAM;
              st     = item_i.oam_int_en;
            end
          end
          MODE_OAM: begin
            mode_d = MODE_XFER;
            st     = item_i.oam_int_en;
          end
          default: begin
            mode_d = MODE_HBLANK;
            draw   = 1'b1;
            hbs    = 1'b1;
            st     = item_i.hblank_int_en;
          end
        endcase
      end
      if (line_d != line_q) begin
        match_d = (line_d == item_i.compare_line);
        if (match_d && item_i.match_int_en) begin
          st = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HBLANK;
      line_q  <= 8'd0;
      dot_q   <= '0;
      match_q <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      dot_q   <= dot_d;
      match_q <= match_d;
    end
  end

  assign result_o.mode         = mode_d;
  assign result_o.line         = line_d;
  assign result_o.coincidence  = match_d;
  assign result_o.vblank_irq   = vb;
  assign result_o.stat_irq     = st;
  assign result_o.draw_line    = draw;
  assign result_o.hblank_start = hbs;

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !item_i.lcd_on) |=> (mode_q == MODE_HBLANK && line_q == 8'd0 && dot_q == '0))
    else $error("lcd off did not clear mode, line and dot counter");

  a_vb_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && vb) |=> (mode_q == MODE_VBLANK))
    else $error("vblank pulse without entering vblank");

  a_draw_hbs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && draw) |=> (mode_q == MODE_HBLANK && $past(mode_q) == MODE_XFER))
    else $error("draw strobe outside transfer to hblank transition");

endmodule

FILE: src/lcd_mode_line_timing_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_mode_line_timing_top
// lcd mode and line sequencer with apb configuration and valid/stall channels
// ----------------------------------------------------------------------------
// Takes one transaction per clock while in_stall_o is low. An accepted item sits
// in an input register, where the combinational state update (saturating dot
// counter add, threshold compare and subtract, mode and line step) produces its
// result into the output register; the item is held in the input register while
// the output is stalled. The input side keeps accepting while a finished result
// waits, as long as the output register is free or being drained in the same
// cycle. The user must write configuration over apb only while the block is
// idle; the block itself does not enforce this.
module lcd_mode_line_timing_top
  import lcdmt_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_item_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_item_t               out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q;
  logic      out_valid_q;
  out_item_t result;
  logic      out_free;
  logic      step;
  logic      in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  lcdmt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcdmt_core #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled while the pipeline can advance");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped item did not reach the output register");

  a_off_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !in_q.lcd_on) |=> (out_q.mode == MODE_HBLANK && out_q.line == 8'd0
      && !out_q.stat_irq && !out_q.vblank_irq && !out_q.draw_line))
    else $error("lcd off transaction produced a non-idle result");

endmodule
